// ===== design/greedy_3d_line_stepper_core_defines.svh =====
// Assertion macros shared by the line stepper RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef GREEDY_3D_LINE_STEPPER_CORE_DEFINES_SVH
`define GREEDY_3D_LINE_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define G3LS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define G3LS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/g3ls_pkg.sv =====
// Shared types, constants and helper functions for the three-axis line stepper.
// No dependencies; imported by every module of the block.
package g3ls_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int MUL_DIGIT_BITS     = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int STEP_CODE_BITS     = 6;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_Z = 2'd2;

   // Last probe number and last product number of the cross product.
   localparam logic [2:0] LAST_PROBE   = 3'd6;
   localparam logic [2:0] LAST_C0_TERM = 3'd5;
   localparam logic [2:0] LAST_SQUARE  = 3'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CLEAR,
      OP_STEP
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_C0_ISSUE,
      ST_C0_WAIT,
      ST_PROBE_START,
      ST_SQ_ISSUE,
      ST_SQ_WAIT,
      ST_PROBE_END,
      ST_FINISH
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   // Axis set of each probe, in the order X, Y, Z, XY, XZ, YZ, XYZ.
   function automatic logic [2:0] probe_axes(logic [2:0] idx);
      logic [2:0] axes;
      case (idx)
         3'd0:    axes = 3'b001;
         3'd1:    axes = 3'b010;
         3'd2:    axes = 3'b100;
         3'd3:    axes = 3'b011;
         3'd4:    axes = 3'b101;
         3'd5:    axes = 3'b110;
         3'd6:    axes = 3'b111;
         default: axes = 3'b000;
      endcase
      return axes;
   endfunction

   // Packs per-axis plus and minus moves into a step code, swapping reversed axes.
   function automatic logic [STEP_CODE_BITS-1:0] step_code(logic [2:0] plus,
                                                           logic [2:0] minus,
                                                           logic [2:0] rev);
      logic [STEP_CODE_BITS-1:0] code;
      for (int a = 0; a < 3; a++) begin
         code[a]     = rev[a] ? minus[a] : plus[a];
         code[a + 3] = rev[a] ? plus[a] : minus[a];
      end
      return code;
   endfunction

endpackage

// ===== design/g3ls_front.sv =====
// Front end of the line stepper: accepts request transfers, classifies them
// and holds them in a short command queue. Depends on g3ls_pkg.
module g3ls_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output g3ls_pkg::op_type             cmd_op,
   output logic signed [COORD_BITS-1:0] cmd_start [3],
   output logic signed [COORD_BITS-1:0] cmd_end [3]
);
   import g3ls_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   op_type                  op_q_ff    [QUEUE_DEPTH];
   logic signed [COORD_BITS-1:0] start_q_ff [QUEUE_DEPTH][3];
   logic signed [COORD_BITS-1:0] end_q_ff   [QUEUE_DEPTH][3];
   logic [PTR_BITS-1:0]     wr_ptr_ff;
   logic [PTR_BITS-1:0]     rd_ptr_ff;
   logic [COUNT_BITS-1:0]   count_ff;
   op_type                  req_op;
   logic                    push;
   logic                    pop;

   // Classify the incoming item: a step, an empty segment or a real load.
   always_comb begin
      if (req_kind) begin
         req_op = OP_STEP;
      end else if (req_start_x == req_end_x && req_start_y == req_end_y &&
                   req_start_z == req_end_z) begin
         req_op = OP_CLEAR;
      end else begin
         req_op = OP_LOAD;
      end
   end

   assign req_ready = (count_ff != COUNT_BITS'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   // Queue head drives the command side.
   always_comb begin
      cmd_op = op_q_ff[rd_ptr_ff];
      for (int a = 0; a < 3; a++) begin
         cmd_start[a] = start_q_ff[rd_ptr_ff][a];
         cmd_end[a]   = end_q_ff[rd_ptr_ff][a];
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                         wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                         rd_ptr_ff + PTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - COUNT_BITS'(1);
         end
      end
   end

   // Queue entries.
   always_ff @(posedge clock) begin
      if (push) begin
         op_q_ff[wr_ptr_ff]       <= req_op;
         start_q_ff[wr_ptr_ff][0] <= req_start_x;
         start_q_ff[wr_ptr_ff][1] <= req_start_y;
         start_q_ff[wr_ptr_ff][2] <= req_start_z;
         end_q_ff[wr_ptr_ff][0]   <= req_end_x;
         end_q_ff[wr_ptr_ff][1]   <= req_end_y;
         end_q_ff[wr_ptr_ff][2]   <= req_end_z;
      end
   end

endmodule

// ===== design/g3ls_mul.sv =====
// Iterative unsigned multiplier: one digit of the second operand per cycle,
// most significant digit first. Depends on g3ls_pkg.
module g3ls_mul #(
   parameter int OPERAND_BITS = 34
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [OPERAND_BITS-1:0]     a,
   input  logic [OPERAND_BITS-1:0]     b,
   output g3ls_pkg::mul_status_type    status,
   output logic [2*OPERAND_BITS-1:0]   product
);
   import g3ls_pkg::*;

   localparam int DIG       = MUL_DIGIT_BITS;
   localparam int NSTEP     = (OPERAND_BITS + DIG - 1) / DIG;
   localparam int BPW       = NSTEP * DIG;
   localparam int PW        = 2 * OPERAND_BITS;
   localparam int CNT_BITS  = $clog2(NSTEP + 1);

   logic [OPERAND_BITS-1:0]     a_ff;
   logic [BPW-1:0]              b_ff;
   logic [PW-1:0]               acc_ff;
   logic [PW-1:0]               acc_in;
   logic [CNT_BITS-1:0]         cnt_ff;
   logic                        done_ff;
   logic [OPERAND_BITS+DIG-1:0] partial;

   // One partial product per cycle, folded into the shifted accumulator.
   assign partial = a_ff * b_ff[BPW-1 -: DIG];
   assign acc_in  = (acc_ff << DIG) + PW'(partial);

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_BITS'(NSTEP);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands and accumulator.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= BPW'(b);
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         acc_ff <= acc_in;
         b_ff   <= b_ff << DIG;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

// ===== design/g3ls_back.sv =====
// Back end of the line stepper: holds the segment state, runs the probe search
// on a shared multiplier and registers the result. Depends on g3ls_pkg, g3ls_mul.
`include "greedy_3d_line_stepper_core_defines.svh"

module g3ls_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  g3ls_pkg::op_type             cmd_op,
   input  logic signed [COORD_BITS-1:0] cmd_start [3],
   input  logic signed [COORD_BITS-1:0] cmd_end [3],
   input  logic [2:0]                   reverse,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [g3ls_pkg::STEP_CODE_BITS-1:0] rsp_step_code,
   output logic                         rsp_segment_done,
   output logic                         rsp_idle,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z
);
   import g3ls_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int DW   = C + 1;          // deltas and point differences
   localparam int KW   = C + 3;          // cross product of delta and a unit step
   localparam int CW   = 2 * C + 3;      // signed cross product component
   localparam int MAGW = 2 * C + 2;      // its magnitude
   localparam int PW   = 2 * MAGW;       // one square
   localparam int SW   = PW + 2;         // sum of three squares

   back_state_type state_ff, state_in;

   // Segment state.
   logic signed [C-1:0]  pos_ff    [3];
   logic signed [C-1:0]  origin_ff [3];
   logic signed [C-1:0]  target_ff [3];
   logic signed [DW-1:0] delta_ff  [3];
   logic                 known_ff;
   logic                 active_ff;

   // Probe search.
   logic signed [CW-1:0] c0_ff [3];
   logic signed [CW-1:0] cp_ff [3];
   logic [SW-1:0]        score_ff;
   logic [SW-1:0]        best_ff;
   logic                 have_ff;
   logic [2:0]           mv_ff;
   logic [2:0]           best_mv_ff;
   logic [2:0]           probe_ff;
   logic [2:0]           sel_ff;

   // Result register.
   logic                      rsp_valid_ff;
   logic [STEP_CODE_BITS-1:0] code_ff;
   logic                      seg_done_ff;
   logic                      idle_ff;
   logic signed [C-1:0]       rpos_ff [3];

   logic                 pop;
   logic                 out_free;
   logic                 rsp_set;
   logic [2:0]           moving;
   logic [2:0]           dneg;
   logic signed [DW-1:0] diff [3];
   logic                 differs;
   logic [2:0]           catch_plus;
   logic [2:0]           catch_minus;
   logic signed [DW-1:0] pb0 [3];
   logic [1:0]           dsel;
   logic [1:0]           psel;
   logic [DW-1:0]        d_mag;
   logic [DW-1:0]        pb_mag;
   logic                 term_neg;
   logic signed [CW-1:0] term;
   logic [MAGW-1:0]      sq_mag;
   logic                 mul_start;
   logic [MAGW-1:0]      mul_a;
   logic [MAGW-1:0]      mul_b;
   mul_status_type       mul_status;
   logic [PW-1:0]        mul_product;
   logic [2:0]           mv_now;
   logic signed [KW-1:0] tk [3][3];
   logic signed [KW-1:0] k [3];
   logic signed [CW-1:0] cp_in [3];
   logic signed [C-1:0]  new_pos [3];
   logic signed [DW-1:0] r [3];
   logic [2:0]           r_unit;
   logic [2:0]           r_nz;
   logic                 fin_done;
   logic [2:0]           fin_plus;
   logic [2:0]           fin_minus;
   logic                 better;

   function automatic logic [DW-1:0] abs_dw(logic signed [DW-1:0] x);
      return x[DW-1] ? $unsigned(-x) : $unsigned(x);
   endfunction

   function automatic logic [CW-1:0] abs_cw(logic signed [CW-1:0] x);
      return x[CW-1] ? $unsigned(-x) : $unsigned(x);
   endfunction

   assign pop      = cmd_valid && cmd_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // A result is loaded by a catch-up load, an idle step or a finished step.
   assign rsp_set  = (pop && cmd_op == OP_LOAD && known_ff && differs) ||
                     (pop && cmd_op == OP_STEP && !active_ff) ||
                     (state_ff == ST_FINISH && out_free);

   // Per-axis direction and the catch-up move on load.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         moving[a]      = (delta_ff[a] != '0);
         dneg[a]        = delta_ff[a][DW-1];
         diff[a]        = DW'(cmd_start[a]) - DW'(pos_ff[a]);
         catch_plus[a]  = !diff[a][DW-1] && (diff[a] != '0);
         catch_minus[a] = diff[a][DW-1];
         pb0[a]         = DW'(origin_ff[a]) - DW'(pos_ff[a]);
      end
      differs = (catch_plus | catch_minus) != 3'b000;
   end

   // Operand selection for the cross product at the current position.
   // Even terms add, odd terms subtract.
   always_comb begin
      case (sel_ff)
         3'd0:    begin dsel = 2'd1; psel = 2'd2; end
         3'd1:    begin dsel = 2'd2; psel = 2'd1; end
         3'd2:    begin dsel = 2'd0; psel = 2'd2; end
         3'd3:    begin dsel = 2'd2; psel = 2'd0; end
         3'd4:    begin dsel = 2'd0; psel = 2'd1; end
         default: begin dsel = 2'd1; psel = 2'd0; end
      endcase
      d_mag    = abs_dw(delta_ff[dsel]);
      pb_mag   = abs_dw(pb0[psel]);
      term_neg = delta_ff[dsel][DW-1] ^ pb0[psel][DW-1] ^ sel_ff[0];
      term     = $signed({1'b0, mul_product[CW-2:0]});
      sq_mag   = MAGW'(abs_cw(cp_ff[sel_ff[1:0]]));
   end

   // Shared multiplier operands.
   always_comb begin
      mul_start = (state_ff == ST_C0_ISSUE) || (state_ff == ST_SQ_ISSUE);
      if (state_ff == ST_SQ_ISSUE) begin
         mul_a = sq_mag;
         mul_b = sq_mag;
      end else begin
         mul_a = MAGW'(d_mag);
         mul_b = MAGW'(pb_mag);
      end
   end

   g3ls_mul #(
      .OPERAND_BITS(MAGW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_status),
      .product (mul_product)
   );

   // Cross product at a probe: the one at the current position minus
   // the cross product of the delta with the probe's unit step.
   always_comb begin
      mv_now = probe_axes(probe_ff) & moving;
      for (int b = 0; b < 3; b++) begin
         for (int c = 0; c < 3; c++) begin
            if (mv_now[c]) begin
               tk[b][c] = dneg[c] ? -KW'(delta_ff[b]) : KW'(delta_ff[b]);
            end else begin
               tk[b][c] = '0;
            end
         end
      end
      k[0] = tk[1][2] - tk[2][1];
      k[1] = tk[0][2] - tk[2][0];
      k[2] = tk[0][1] - tk[1][0];
      for (int a = 0; a < 3; a++) begin
         cp_in[a] = c0_ff[a] - CW'(k[a]);
      end
      better = !have_ff || (score_ff < best_ff);
   end

   // Move to the winning probe and test for the end point.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fin_plus[a]  = best_mv_ff[a] && !dneg[a];
         fin_minus[a] = best_mv_ff[a] && dneg[a];
         if (fin_plus[a]) begin
            new_pos[a] = pos_ff[a] + C'(1);
         end else if (fin_minus[a]) begin
            new_pos[a] = pos_ff[a] - C'(1);
         end else begin
            new_pos[a] = pos_ff[a];
         end
         r[a]      = DW'(new_pos[a]) - DW'(target_ff[a]);
         r_nz[a]   = (r[a] != '0);
         r_unit[a] = !r_nz[a] || (r[a] == DW'(1)) || (r[a] == -DW'(1));
      end
      fin_done = (r_unit == 3'b111) &&
                 !((r_nz[0] && r_nz[1]) || (r_nz[0] && r_nz[2]) || (r_nz[1] && r_nz[2]));
   end

   // Sequencer: next state and command acceptance.
   always_comb begin
      state_in  = state_ff;
      cmd_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_op)
                  OP_CLEAR: cmd_ready = 1'b1;
                  OP_LOAD:  cmd_ready = out_free;
                  OP_STEP: begin
                     if (active_ff) begin
                        cmd_ready = 1'b1;
                        state_in  = ST_C0_ISSUE;
                     end else begin
                        cmd_ready = out_free;
                     end
                  end
                  default:  cmd_ready = 1'b1;
               endcase
            end
         end
         ST_C0_ISSUE: state_in = ST_C0_WAIT;
         ST_C0_WAIT: begin
            if (mul_status.done) begin
               state_in = (sel_ff == LAST_C0_TERM) ? ST_PROBE_START : ST_C0_ISSUE;
            end
         end
         ST_PROBE_START: begin
            if (mv_now != 3'b000) begin
               state_in = ST_SQ_ISSUE;
            end else if (probe_ff == LAST_PROBE) begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ_ISSUE: state_in = ST_SQ_WAIT;
         ST_SQ_WAIT: begin
            if (mul_status.done) begin
               state_in = (sel_ff == LAST_SQUARE) ? ST_PROBE_END : ST_SQ_ISSUE;
            end
         end
         ST_PROBE_END: state_in = (probe_ff == LAST_PROBE) ? ST_FINISH : ST_PROBE_START;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Segment state, counters and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            pos_ff[a]    <= '0;
            origin_ff[a] <= '0;
            target_ff[a] <= '0;
            delta_ff[a]  <= '0;
         end
         known_ff     <= 1'b0;
         active_ff    <= 1'b0;
         have_ff      <= 1'b0;
         sel_ff       <= '0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result takes priority over the transfer of the old one.
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pop) begin
            case (cmd_op)
               OP_CLEAR: active_ff <= 1'b0;
               OP_LOAD: begin
                  for (int a = 0; a < 3; a++) begin
                     origin_ff[a] <= cmd_start[a];
                     target_ff[a] <= cmd_end[a];
                     delta_ff[a]  <= DW'(cmd_end[a]) - DW'(cmd_start[a]);
                     pos_ff[a]    <= cmd_start[a];
                  end
                  known_ff  <= 1'b1;
                  active_ff <= 1'b1;
               end
               OP_STEP: begin
                  have_ff  <= 1'b0;
                  sel_ff   <= '0;
                  probe_ff <= '0;
               end
               default: ;
            endcase
         end
         if ((state_ff == ST_C0_WAIT || state_ff == ST_SQ_WAIT) && mul_status.done) begin
            if ((state_ff == ST_C0_WAIT && sel_ff == LAST_C0_TERM) ||
                (state_ff == ST_SQ_WAIT && sel_ff == LAST_SQUARE)) begin
               sel_ff <= '0;
            end else begin
               sel_ff <= sel_ff + 3'd1;
            end
         end
         if (state_ff == ST_PROBE_START && mv_now == 3'b000 && probe_ff != LAST_PROBE) begin
            probe_ff <= probe_ff + 3'd1;
         end
         if (state_ff == ST_PROBE_END) begin
            if (better) begin
               have_ff <= 1'b1;
            end
            if (probe_ff != LAST_PROBE) begin
               probe_ff <= probe_ff + 3'd1;
            end
         end
         if (state_ff == ST_FINISH && out_free) begin
            for (int a = 0; a < 3; a++) begin
               pos_ff[a] <= new_pos[a];
            end
            if (fin_done) begin
               active_ff <= 1'b0;
            end
         end
      end
   end

   // Search datapath and result payload.
   always_ff @(posedge clock) begin
      if (pop && cmd_op == OP_STEP) begin
         for (int a = 0; a < 3; a++) begin
            c0_ff[a] <= '0;
         end
      end
      if (state_ff == ST_C0_WAIT && mul_status.done) begin
         c0_ff[sel_ff[2:1]] <= c0_ff[sel_ff[2:1]] + (term_neg ? -term : term);
      end
      if (state_ff == ST_PROBE_START && mv_now != 3'b000) begin
         for (int a = 0; a < 3; a++) begin
            cp_ff[a] <= cp_in[a];
         end
         score_ff <= '0;
         mv_ff    <= mv_now;
      end
      if (state_ff == ST_SQ_WAIT && mul_status.done) begin
         score_ff <= score_ff + SW'(mul_product);
      end
      if (state_ff == ST_PROBE_END && better) begin
         best_ff    <= score_ff;
         best_mv_ff <= mv_ff;
      end
      if (pop && cmd_op == OP_LOAD && known_ff && differs) begin
         code_ff     <= step_code(catch_plus, catch_minus, reverse);
         seg_done_ff <= 1'b0;
         idle_ff     <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            rpos_ff[a] <= cmd_start[a];
         end
      end
      if (pop && cmd_op == OP_STEP && !active_ff) begin
         code_ff     <= '0;
         seg_done_ff <= 1'b0;
         idle_ff     <= 1'b1;
         for (int a = 0; a < 3; a++) begin
            rpos_ff[a] <= pos_ff[a];
         end
      end
      if (state_ff == ST_FINISH && out_free) begin
         code_ff     <= step_code(fin_plus, fin_minus, reverse);
         seg_done_ff <= fin_done;
         idle_ff     <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            rpos_ff[a] <= new_pos[a];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_step_code    = code_ff;
   assign rsp_segment_done = seg_done_ff;
   assign rsp_idle         = idle_ff;
   assign rsp_pos_x        = rpos_ff[0];
   assign rsp_pos_y        = rpos_ff[1];
   assign rsp_pos_z        = rpos_ff[2];

   // Checks on the sequencer and the shared multiplier.
   `G3LS_ASSERT_IMPLY(a_pop_only_idle, clock, reset, cmd_valid && cmd_ready, state_ff == ST_IDLE, "command taken while a step is in progress")
   `G3LS_ASSERT_IMPLY(a_mul_start_free, clock, reset, mul_start, !mul_status.busy, "multiplier started while busy")
   `G3LS_ASSERT_IMPLY(a_finish_has_best, clock, reset, state_ff == ST_FINISH, have_ff, "step finished without a chosen probe")
   `G3LS_ASSERT_NEXT(a_done_clears_active, clock, reset, state_ff == ST_FINISH && out_free && fin_done, !active_ff && rsp_segment_done, "finished segment still active")

endmodule

// ===== design/greedy_3d_line_stepper_core.sv =====
// Top level of the three-axis line stepper: configuration registers, front end
// and back end. Depends on g3ls_pkg, g3ls_front, g3ls_back (and g3ls_mul).
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   kind, segment start and end
//   rsp      out        rsp_valid/rsp_ready   step code, done, idle, position
//   csr      in         csr_we                register index and one data bit
//
// A load with catch-up or a step with no segment raises rsp_valid in the cycle after
// its transfer; a clear or a plain load gives no result. A step on an active
// segment runs up to 27 products on one shared multiplier, each one issued, worked
// through one 16-bit digit at a time and then handed off. A two-entry queue takes
// requests while a step is in work; a full result register stalls loads, idle
// steps and the step finish. Reset is synchronous.
module greedy_3d_line_stepper_core #(
   parameter int COORD_BITS = g3ls_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [g3ls_pkg::STEP_CODE_BITS-1:0] rsp_step_code,
   output logic                         rsp_segment_done,
   output logic                         rsp_idle,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   input  logic                         csr_we,
   input  logic [g3ls_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic                         csr_wdata
);
   import g3ls_pkg::*;

   logic [2:0]                   reverse_ff;
   logic                         cmd_valid;
   logic                         cmd_ready;
   op_type                       cmd_op;
   logic signed [COORD_BITS-1:0] cmd_start [3];
   logic signed [COORD_BITS-1:0] cmd_end [3];

   // Axis reversal registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REVERSE_X: reverse_ff[0] <= csr_wdata;
            CSR_REVERSE_Y: reverse_ff[1] <= csr_wdata;
            CSR_REVERSE_Z: reverse_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   g3ls_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_start_z (req_start_z),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_end_z   (req_end_z),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd_op      (cmd_op),
      .cmd_start   (cmd_start),
      .cmd_end     (cmd_end)
   );

   g3ls_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_op           (cmd_op),
      .cmd_start        (cmd_start),
      .cmd_end          (cmd_end),
      .reverse          (reverse_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_step_code    (rsp_step_code),
      .rsp_segment_done (rsp_segment_done),
      .rsp_idle         (rsp_idle),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z)
   );

endmodule
